// ----- rtl/bels_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bels_pkg
// Shared constants and types for the BOSS edge label scan.
// ----------------------------------------------------------------------------
package bels_pkg;

  localparam int MAX_K_DEF      = 15;
  localparam int COUNT_BITS_DEF = 32;
  localparam int SYM_BITS       = 4;
  localparam int NUM_COUNTS     = 16;
  localparam int MARK_BITS      = 15;
  localparam int KMER_BITS      = 64;
  localparam int ADDR_BITS      = 4;

  localparam logic [1:0] REG_KMER_LENGTH = 2'd0;
  localparam logic [1:0] REG_MULTIGRAPH  = 2'd1;
  localparam logic [1:0] REG_ALPHABET    = 2'd2;

  localparam logic ACT_KMER = 1'b0;
  localparam logic ACT_END  = 1'b1;

  localparam logic KIND_EDGE  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  localparam logic [3:0] SYM_UNMARKABLE = 4'd15;

  // per-lane compare result; symbols are zero unless the lane holds that position
  typedef struct packed {
    logic       node_diff;
    logic       suffix_diff;
    logic [3:0] edge_x;
    logic [3:0] edge_p;
    logic [3:0] last_x;
  } lane_t;

endpackage

// ----- rtl/bels_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bels_lane
// One symbol position: compares against the previous item and selects the
// symbol when it sits at the edge or last node position.
// ----------------------------------------------------------------------------
module bels_lane #(
  parameter int LANE = 0
) (
  input  logic [3:0]     sym_x,
  input  logic [3:0]     sym_p,
  input  logic [3:0]     k,
  output bels_pkg::lane_t res
);
  import bels_pkg::*;

  localparam logic [3:0] POS = 4'(LANE);

  logic diff;
  logic is_edge;
  logic is_last;

  assign diff    = (sym_x != sym_p);
  assign is_edge = (k == POS);
  assign is_last = (k == POS + 4'd1);

  always_comb begin
    res.node_diff   = diff && (POS < k);
    res.suffix_diff = diff && (POS != 4'd0) && (POS < k);
    res.edge_x      = is_edge ? sym_x : 4'd0;
    res.edge_p      = is_edge ? sym_p : 4'd0;
    res.last_x      = is_last ? sym_x : 4'd0;
  end

endmodule

// ----- rtl/bels_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bels_merge
// Combines the lane results: change flags and selected symbols.
// ----------------------------------------------------------------------------
module bels_merge #(
  parameter int LANES = 16
) (
  input  bels_pkg::lane_t lanes [LANES],
  output bels_pkg::lane_t merged
);
  import bels_pkg::*;

  always_comb begin
    merged = '0;
    for (int j = 0; j < LANES; j++) begin
      merged.node_diff   = merged.node_diff   | lanes[j].node_diff;
      merged.suffix_diff = merged.suffix_diff | lanes[j].suffix_diff;
      merged.edge_x      = merged.edge_x      | lanes[j].edge_x;
      merged.edge_p      = merged.edge_p      | lanes[j].edge_p;
      merged.last_x      = merged.last_x      | lanes[j].last_x;
    end
  end

endmodule

// ----- rtl/bels_counts.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bels_counts
// Saturating edge counters, one per last node symbol, with a read port for
// the end-of-stream sweep.
// ----------------------------------------------------------------------------
module bels_counts #(
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  inc_en,
  input  logic [3:0]            inc_idx,
  input  logic                  clear,
  input  logic [3:0]            rd_idx,
  output logic [COUNT_BITS-1:0] rd_data
);
  import bels_pkg::*;

  logic [COUNT_BITS-1:0] cnt [NUM_COUNTS];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int j = 0; j < NUM_COUNTS; j++) cnt[j] <= '0;
    end else if (inc_en) begin
      if (cnt[inc_idx] != '1) cnt[inc_idx] <= cnt[inc_idx] + 1'b1;
    end
  end

  assign rd_data = cnt[rd_idx];

endmodule

// ----- rtl/boss_edge_label_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boss_edge_label_scan
// Scans sorted (k+1)-mers and emits BOSS edge labels and per-symbol counts.
// ----------------------------------------------------------------------------
// A k-mer item is taken every clock while item_stall is low and gives one
// edge result in the next cycle: MAX_K+1 symbol lanes compare it with the
// previous item in parallel. After an end item is taken, its 2*sigma+2 count
// results leave one per cycle from the single counter read port while
// result_stall is low, and items are stalled meanwhile. Stream state clears
// with the last count result. Register map: 0x0 kmer_length, 0x4
// multigraph_mode, 0x8 sigma.
module boss_edge_label_scan #(
  parameter int MAX_K      = bels_pkg::MAX_K_DEF,
  parameter int COUNT_BITS = bels_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bels_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic                           action,
  input  logic [bels_pkg::KMER_BITS-1:0] kmer_symbols,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic                           result_kind,
  output logic                           edge_added,
  output logic [3:0]                     edge_label,
  output logic                           closes_previous_node,
  output logic [3:0]                     count_index,
  output logic [31:0]                    count_value,
  output logic [31:0]                    node_total,
  output logic                           last_result
);
  import bels_pkg::*;

  localparam int LANES = MAX_K + 1;

  logic [3:0] kmer_length;
  logic       multigraph_mode;
  logic [2:0] sigma;

  logic [KMER_BITS-1:0]  previous_kmer;
  logic                  have_previous;
  logic                  any_edge;
  logic [MARK_BITS-1:0]  marks;
  logic [MARK_BITS-1:0]  marks_next;
  logic [COUNT_BITS-1:0] node_counter;
  logic [COUNT_BITS-1:0] node_counter_next;

  logic                  sweep;
  logic [3:0]            sidx;
  logic [COUNT_BITS-1:0] run;
  logic [COUNT_BITS-1:0] run_next;
  logic [COUNT_BITS:0]   run_sum;

  logic [3:0] k_eff;
  logic [3:0] ext;
  logic       cfg_wr;
  logic       accept;
  logic       adv;
  logic       load_edge;
  logic       load_count;
  logic       sweep_done;

  lane_t lanes [LANES];
  lane_t merged;

  logic       is_new_node;
  logic       adds_edge;
  logic       clear_marks;
  logic [3:0] label;
  logic [4:0] label_sum;
  logic [COUNT_BITS-1:0] cnt_rd;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length     <= 4'd3;
      multigraph_mode <= 1'b0;
      sigma           <= 3'd4;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_KMER_LENGTH: kmer_length     <= pwdata[3:0];
        REG_MULTIGRAPH:  multigraph_mode <= pwdata[0];
        REG_ALPHABET:    sigma           <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_KMER_LENGTH: prdata = {28'd0, kmer_length};
      REG_MULTIGRAPH:  prdata = {31'd0, multigraph_mode};
      REG_ALPHABET:    prdata = {29'd0, sigma};
      default:         prdata = '0;
    endcase
  end

  // handshake
  assign adv        = !result_valid || !result_stall;
  assign item_stall = sweep || !adv;
  assign accept     = item_valid && !item_stall;
  assign load_edge  = accept && (action == ACT_KMER);
  assign load_count = sweep && adv;
  assign ext        = {sigma, 1'b1};
  assign sweep_done = load_count && (sidx == ext);

  assign k_eff = (kmer_length < 4'd2) ? 4'd2 :
                 (kmer_length > 4'(MAX_K)) ? 4'(MAX_K) : kmer_length;

  // symbol lanes
  for (genvar j = 0; j < LANES; j++) begin : g_lane
    bels_lane #(.LANE(j)) u_lane (
      .sym_x (kmer_symbols[SYM_BITS*j +: SYM_BITS]),
      .sym_p (previous_kmer[SYM_BITS*j +: SYM_BITS]),
      .k     (k_eff),
      .res   (lanes[j])
    );
  end

  bels_merge #(.LANES(LANES)) u_merge (
    .lanes  (lanes),
    .merged (merged)
  );

  // edge decision
  always_comb begin
    is_new_node = !have_previous || merged.node_diff;
    if (is_new_node) begin
      adds_edge = 1'b1;
    end else if (merged.edge_x != merged.edge_p) begin
      adds_edge = 1'b1;
    end else begin
      adds_edge = multigraph_mode;
    end
    clear_marks = !have_previous || merged.suffix_diff;
    marks_next  = clear_marks ? '0 : marks;
    label_sum   = {1'b0, merged.edge_x} + {2'b00, sigma};
    label       = 4'd0;
    if (adds_edge) begin
      label = merged.edge_x;
      if (merged.edge_x != SYM_UNMARKABLE) begin
        if (marks_next[merged.edge_x]) begin
          label = (merged.edge_x > {1'b0, sigma}) ? merged.edge_x : label_sum[3:0];
        end else begin
          marks_next[merged.edge_x] = 1'b1;
        end
      end
    end
    node_counter_next = node_counter;
    if (is_new_node && node_counter != '1) node_counter_next = node_counter + 1'b1;
  end

  bels_counts #(.COUNT_BITS(COUNT_BITS)) u_counts (
    .clk     (clk),
    .rst     (rst),
    .inc_en  (load_edge && adds_edge),
    .inc_idx (merged.last_x),
    .clear   (sweep_done),
    .rd_idx  (sidx),
    .rd_data (cnt_rd)
  );

  assign run_sum  = {1'b0, run} + {1'b0, cnt_rd};
  assign run_next = run_sum[COUNT_BITS] ? '1 : run_sum[COUNT_BITS-1:0];

  // stream state
  always_ff @(posedge clk) begin
    if (rst || sweep_done) begin
      have_previous <= 1'b0;
      any_edge      <= 1'b0;
      marks         <= '0;
      node_counter  <= '0;
      previous_kmer <= '0;
    end else if (load_edge) begin
      have_previous <= 1'b1;
      any_edge      <= any_edge || adds_edge;
      marks         <= marks_next;
      node_counter  <= node_counter_next;
      previous_kmer <= kmer_symbols;
    end
  end

  // count sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= 1'b0;
      sidx  <= 4'd0;
      run   <= '0;
    end else if (accept && (action == ACT_END)) begin
      sweep <= 1'b1;
      sidx  <= 4'd0;
      run   <= '0;
    end else if (load_count) begin
      sweep <= !sweep_done;
      sidx  <= sidx + 4'd1;
      run   <= run_next;
    end
  end

  function automatic logic [31:0] clip32(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS-1:0] hi;
    hi = v >> 32;
    return (hi != '0) ? 32'hFFFF_FFFF : 32'(v);
  endfunction

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= load_edge || load_count;
    end
  end

  always_ff @(posedge clk) begin
    if (load_edge) begin
      result_kind          <= KIND_EDGE;
      edge_added           <= adds_edge;
      edge_label           <= label;
      closes_previous_node <= is_new_node && any_edge;
      count_index          <= 4'd0;
      count_value          <= 32'd0;
      node_total           <= clip32(node_counter_next);
      last_result          <= 1'b1;
    end else if (load_count) begin
      result_kind          <= KIND_COUNT;
      edge_added           <= 1'b0;
      edge_label           <= 4'd0;
      closes_previous_node <= (sidx == 4'd0) && any_edge;
      count_index          <= sidx;
      count_value          <= clip32(run);
      node_total           <= clip32(node_counter);
      last_result          <= sweep_done;
    end
  end

`ifndef ASSERT_OFF
  a_end_starts_sweep: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_END) |=> sweep)
    else $error("end item did not start the count sweep");

  a_sweep_clears: assert property (@(posedge clk) disable iff (rst)
    sweep_done |=> (!have_previous && node_counter == '0 && !sweep))
    else $error("stream state not cleared after count sweep");

  a_last_count: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind == KIND_COUNT) |-> (last_result == (count_index == ext)))
    else $error("last count result flag mismatch");

  a_no_item_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweep |-> !accept)
    else $error("item accepted during count sweep");
`endif

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the BOSS edge label scan.
// ----------------------------------------------------------------------------
// Writes the three registers over the APB port, sends a directed set of
// k-mer and end items, then random streams. The streams are mostly random walks
// that keep node prefixes and suffixes, so that duplicates, extra edges and
// marked labels all occur. A scoreboard predicts every result and checks each
// one as it arrives. Both sides idle and stall at random.
module testbench;
  import bels_pkg::*;

  localparam int LIMIT       = 200000;
  localparam int KMER_TARGET = 350;

  typedef struct {
    logic        kind;
    logic        edge_added;
    logic [3:0]  label;
    logic        closes;
    logic [3:0]  index;
    logic [31:0] value;
    logic [31:0] total;
    logic        last;
  } scan_result_t;

  class edge_scoreboard;
    int unsigned  node_len;
    logic         multi;
    logic [2:0]   sigma;
    logic [63:0]  prev_kmer;
    bit           have_prev;
    bit           any_edge;
    logic [14:0]  marks;
    logic [31:0]  counts[16];
    logic [31:0]  nodes;
    scan_result_t expected_q[$];
    int           errors;

    function new();
      node_len = 3;
      multi = 1'b0;
      sigma = 3'd4;
      errors = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      prev_kmer = '0;
      have_prev = 0;
      any_edge = 0;
      marks = '0;
      foreach (counts[i]) counts[i] = '0;
      nodes = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_KMER_LENGTH: node_len = val[3:0];
        REG_MULTIGRAPH:  multi = val[0];
        REG_ALPHABET:    sigma = val[2:0];
        default: ;
      endcase
    endfunction

    function automatic logic [31:0] sat_inc(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function void note_item(logic act, logic [63:0] sym);
      scan_result_t r;
      int unsigned  k, n, i;
      logic [32:0]  run;
      logic [63:0]  mask;
      logic [3:0]   e, pe, ls, lbl;
      bit           new_node, added, cls;
      if (act == ACT_END) begin
        n = 2 * sigma + 1;
        run = '0;
        for (i = 0; i <= n; i++) begin
          r = '{KIND_COUNT, 1'b0, 4'd0, (i == 0) && any_edge, 4'(i), run[31:0], nodes,
                i == n};
          expected_q.push_back(r);
          run = run + counts[i % 16];
          if (run > 33'hFFFF_FFFF) run = 33'hFFFF_FFFF;
        end
        clear_stream();
        return;
      end
      k = node_len;
      if (k < 2) k = 2;
      if (k > MAX_K_DEF) k = MAX_K_DEF;
      mask = (64'd1 << (4 * k)) - 64'd1;
      e  = 4'(sym >> (4 * k));
      pe = 4'(prev_kmer >> (4 * k));
      ls = 4'(sym >> (4 * (k - 1)));
      new_node = !have_prev || (((sym ^ prev_kmer) & mask) != 0);
      cls = 0;
      if (new_node) begin
        cls = any_edge;
        nodes = sat_inc(nodes);
        added = 1;
      end else if (e != pe) begin
        added = 1;
      end else begin
        added = multi;
      end
      if (!have_prev || (((sym ^ prev_kmer) & mask & ~64'hF) != 0)) marks = '0;
      lbl = 4'd0;
      if (added) begin
        lbl = e;
        if (e != SYM_UNMARKABLE) begin
          if (marks[e]) lbl = (e > sigma) ? e : e + 4'(sigma);
          else marks[e] = 1'b1;
        end
        counts[ls] = sat_inc(counts[ls]);
        any_edge = 1;
      end
      prev_kmer = sym;
      have_prev = 1;
      r = '{KIND_EDGE, added, lbl, cls, 4'd0, 32'd0, nodes, 1'b1};
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] exp, logic [31:0] got);
      if (got !== exp) begin
        $error("%s: expected %0h, got %0h", name, exp, got);
        errors++;
      end
    endfunction

    function void check_result(scan_result_t got);
      scan_result_t exp;
      if (expected_q.size() == 0) begin
        $error("result arrived with nothing expected");
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      check_field("result_kind", exp.kind, got.kind);
      check_field("edge_added", exp.edge_added, got.edge_added);
      check_field("edge_label", exp.label, got.label);
      check_field("closes_previous_node", exp.closes, got.closes);
      check_field("count_index", exp.index, got.index);
      check_field("count_value", exp.value, got.value);
      check_field("node_total", exp.total, got.total);
      check_field("last_result", exp.last, got.last);
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 item_valid;
  logic                 item_stall;
  logic                 action;
  logic [KMER_BITS-1:0] kmer_symbols;
  logic                 result_valid;
  logic                 result_stall;
  logic                 result_kind;
  logic                 edge_added;
  logic [3:0]           edge_label;
  logic                 closes_previous_node;
  logic [3:0]           count_index;
  logic [31:0]          count_value;
  logic [31:0]          node_total;
  logic                 last_result;

  edge_scoreboard sb = new();
  bit             no_gaps = 0;
  int             cycles = 0;

  boss_edge_label_scan dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_stall(item_stall),
    .action(action), .kmer_symbols(kmer_symbols),
    .result_valid(result_valid), .result_stall(result_stall),
    .result_kind(result_kind), .edge_added(edge_added), .edge_label(edge_label),
    .closes_previous_node(closes_previous_node), .count_index(count_index),
    .count_value(count_value), .node_total(node_total), .last_result(last_result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic bit gap_roll();
    return !no_gaps && ($urandom_range(99) < 15);
  endfunction

  always @(negedge clk) result_stall <= gap_roll();

  initial begin : result_side
    scan_result_t got;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        got = '{result_kind, edge_added, edge_label, closes_previous_node, count_index,
                count_value, node_total, last_result};
        sb.check_result(got);
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_cfg(input int unsigned k, input logic m, input logic [2:0] s);
    write_reg(REG_KMER_LENGTH, k);
    write_reg(REG_MULTIGRAPH, {31'd0, m});
    write_reg(REG_ALPHABET, {29'd0, s});
  endtask

  task automatic send_item(input logic act, input logic [63:0] sym);
    @(negedge clk);
    while (gap_roll()) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    action <= act;
    kmer_symbols <= sym;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(act, sym);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [3:0] pick_sym(logic [2:0] sig);
    return ($urandom_range(19) == 0) ? 4'($urandom) : 4'($urandom_range(sig));
  endfunction

  // random walk over k-mers: mostly small edits so that nodes and suffixes repeat
  function automatic logic [63:0] next_kmer(logic [63:0] prev, bit fresh,
                                            int unsigned kraw, logic [2:0] sig);
    logic [63:0] x;
    int unsigned k, roll, p, i;
    k = (kraw < 2) ? 2 : (kraw > MAX_K_DEF) ? MAX_K_DEF : kraw;
    x = prev;
    roll = fresh ? 99 : $urandom_range(99);
    if (roll < 30) begin
      x[4*k +: 4] = pick_sym(sig);
    end else if (roll < 40) begin
      x = prev;
    end else if (roll < 60) begin
      x[3:0] = pick_sym(sig);
      if ($urandom_range(1) == 1) x[4*k +: 4] = pick_sym(sig);
    end else if (roll < 85) begin
      p = $urandom_range(k - 1);
      x[4*p +: 4] = pick_sym(sig);
      x[4*k +: 4] = pick_sym(sig);
    end else begin
      for (i = 0; i <= k; i++) x[4*i +: 4] = pick_sym(sig);
    end
    for (i = k + 1; i < 16; i++) x[4*i +: 4] = ($urandom_range(9) == 0) ? 4'($urandom) : 4'd0;
    return x;
  endfunction

  initial begin : stimulus
    int unsigned kc;
    logic        mc;
    logic [2:0]  sc;
    int          kmers_sent, phase, nstreams, len, s, j;
    logic [63:0] walk;
    bit          fresh;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_valid = 1'b0;
    action = ACT_KMER;
    kmer_symbols = '0;
    result_stall = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: k = 3, sigma = 4
    send_item(ACT_KMER, 64'h0000);
    send_item(ACT_KMER, 64'h0000);
    send_item(ACT_KMER, 64'h1000);
    send_item(ACT_KMER, 64'h1001);
    send_item(ACT_KMER, 64'h6001);
    send_item(ACT_KMER, 64'h6002);
    send_item(ACT_KMER, 64'hF002);
    send_item(ACT_KMER, 64'hF003);
    send_item(ACT_KMER, 64'h2213);
    send_item(ACT_KMER, 64'hFFFF);
    send_item(ACT_KMER, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ACT_KMER, 64'hAAAA_5555_AAAA_1234);
    send_item(ACT_END, 64'h5A5A_A5A5_FFFF_0000);
    send_item(ACT_END, 64'h0);
    wait_idle();
    // length below range, multigraph, empty alphabet
    set_cfg(1, 1'b1, 3'd0);
    send_item(ACT_KMER, 64'h000);
    send_item(ACT_KMER, 64'h000);
    send_item(ACT_KMER, 64'h010);
    send_item(ACT_END, 64'h0);
    wait_idle();
    // longest label, largest alphabet
    set_cfg(15, 1'b0, 3'd7);
    send_item(ACT_KMER, 64'h1654_3210_7654_3210);
    send_item(ACT_KMER, 64'h7654_3210_7654_3210);
    send_item(ACT_KMER, 64'h7654_3210_7654_3211);
    send_item(ACT_END, 64'h0);

    kmers_sent = 0;
    phase = 0;
    fresh = 1;
    walk = '0;
    while (kmers_sent < KMER_TARGET) begin
      wait_idle();
      case (phase)
        0: begin kc = 2; mc = 1'b0; sc = 3'd1; end
        1: begin kc = 15; mc = 1'b1; sc = 3'd7; end
        3: begin kc = 0; mc = 1'($urandom_range(1)); sc = 3'($urandom_range(7)); end
        default: begin
          kc = $urandom_range(2, 15);
          mc = 1'($urandom_range(1));
          sc = 3'($urandom_range(7));
        end
      endcase
      no_gaps = (phase == 2);
      set_cfg(kc, mc, sc);
      nstreams = $urandom_range(1, 4);
      for (s = 0; s < nstreams; s++) begin
        len = ($urandom_range(4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        for (j = 0; j < len; j++) begin
          walk = next_kmer(walk, fresh, kc, sc);
          fresh = 0;
          send_item(ACT_KMER, walk);
          kmers_sent++;
        end
        // now and then the stream runs on into the next setting
        if (s < nstreams - 1 || $urandom_range(3) != 0) begin
          send_item(ACT_END, {$urandom, $urandom});
          fresh = 1;
        end
      end
      phase++;
    end
    no_gaps = 0;
    send_item(ACT_END, 64'h0);
    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      $error("%0d results never arrived", sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
